### hw/rtl/hrcv_pkg.sv
// Shared types and constants of the HEX record checksum verifier.
`timescale 1ns / 1ps

package hrcv_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_CSUM = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_EXP    = 1'b1;

	// Event codes
	localparam logic [2:0] EV_REC_OK   = 3'd0;
	localparam logic [2:0] EV_REC_BAD  = 3'd1;
	localparam logic [2:0] EV_FIN_OK   = 3'd2;
	localparam logic [2:0] EV_FIN_VERR = 3'd3;
	localparam logic [2:0] EV_NO_MARK  = 3'd4;

	// Stream constants
	localparam logic [7:0]  FILE_MARK  = 8'h5D;
	localparam logic [7:0]  EOF_TYPE   = 8'h01;
	localparam logic [2:0]  MARK_LIMIT = 3'd5;
	localparam logic [15:0] SAT_MAX    = 16'hFFFF;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] row_index;
		logic [7:0]  calc_checksum;
		logic [7:0]  stored_checksum;
		logic [15:0] error_count;
		logic [15:0] vertical_sum;
		logic        last;
	} res_t;

	// Up to two results produced by one item, first in res0
	typedef struct packed {
		logic push0;
		logic push1;
		res_t res0;
		res_t res1;
	} push_t;

endpackage

### hw/rtl/hrcv_checker.sv
// Record walker: phase tracking, record sum and result generation per byte.
`timescale 1ns / 1ps

module hrcv_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         global_checksum,
	input  logic [15:0]         rows_expected,
	output hrcv_pkg::push_t     pending
);

	typedef enum logic [3:0] {
		PH_MARK,
		PH_MARKER,
		PH_COUNT,
		PH_ADDR_HI,
		PH_ADDR_LO,
		PH_TYPE,
		PH_DATA,
		PH_CSUM,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  tries_q, tries_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] rows_q, rows_d;
	logic [15:0] bad_q, bad_d;
	logic [15:0] good_q, good_d;

	logic [7:0]  calc;
	logic        mismatch;
	logic        stop;
	logic [2:0]  tries_inc;
	logic [7:0]  left_dec;
	logic [15:0] rows_inc;
	hrcv_pkg::res_t r0, r1;

	assign calc      = 8'd0 - sum_q;
	assign mismatch  = (calc != data_byte);
	assign tries_inc = tries_q + 3'd1;
	assign left_dec  = left_q - 8'd1;
	assign rows_inc  = rows_q + 16'd1;

	always_comb begin
		phase_d = phase_q;
		tries_d = tries_q;
		len_d   = len_q;
		left_d  = left_q;
		sum_d   = sum_q;
		rows_d  = rows_q;
		bad_d   = bad_q;
		good_d  = good_q;
		stop    = 1'b0;
		r0      = '0;
		r1      = '0;
		pending = '0;
		if (take) begin
			case (phase_q)
				PH_MARK: begin
					tries_d = tries_inc;
					if (tries_inc >= hrcv_pkg::MARK_LIMIT) begin
						r0.event_res  = hrcv_pkg::EV_NO_MARK;
						r0.last       = 1'b1;
						pending.push0 = 1'b1;
						phase_d       = PH_DONE;
					end else if (data_byte == hrcv_pkg::FILE_MARK) begin
						phase_d = PH_MARKER;
					end
				end
				PH_MARKER: phase_d = PH_COUNT;
				PH_COUNT: begin
					len_d   = data_byte;
					left_d  = data_byte;
					sum_d   = data_byte;
					phase_d = PH_ADDR_HI;
				end
				PH_ADDR_HI: begin
					sum_d   = sum_q + data_byte;
					phase_d = PH_ADDR_LO;
				end
				PH_ADDR_LO: begin
					sum_d   = sum_q + data_byte;
					phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					if (data_byte == hrcv_pkg::EOF_TYPE) begin
						// end-of-file record: counts as a row, no checksum byte
						rows_d          = rows_inc;
						r0.event_res    = (good_q == global_checksum) ?
						                  hrcv_pkg::EV_FIN_OK : hrcv_pkg::EV_FIN_VERR;
						r0.row_index    = rows_inc;
						r0.error_count  = bad_q;
						r0.vertical_sum = good_q;
						r0.last         = 1'b1;
						pending.push0   = 1'b1;
						phase_d         = PH_DONE;
					end else begin
						sum_d   = sum_q + data_byte;
						phase_d = (len_q != 8'd0) ? PH_DATA : PH_CSUM;
					end
				end
				PH_DATA: begin
					sum_d  = sum_q + data_byte;
					left_d = left_dec;
					if (left_dec == 8'd0) begin
						phase_d = PH_CSUM;
					end
				end
				PH_CSUM: begin
					if (mismatch) begin
						if (bad_q != hrcv_pkg::SAT_MAX) begin
							bad_d = bad_q + 16'd1;
						end
					end else begin
						good_d = good_q + {8'd0, data_byte};
					end
					rows_d = rows_inc;
					stop   = (rows_inc >= rows_expected);
					r0.event_res       = mismatch ? hrcv_pkg::EV_REC_BAD :
					                     hrcv_pkg::EV_REC_OK;
					r0.row_index       = rows_q;
					r0.calc_checksum   = calc;
					r0.stored_checksum = data_byte;
					r0.error_count     = bad_d;
					r0.vertical_sum    = good_d;
					r0.last            = !stop;
					pending.push0      = 1'b1;
					if (stop) begin
						r1.event_res    = (good_d == global_checksum) ?
						                  hrcv_pkg::EV_FIN_OK : hrcv_pkg::EV_FIN_VERR;
						r1.row_index    = rows_inc;
						r1.error_count  = bad_d;
						r1.vertical_sum = good_d;
						r1.last         = 1'b1;
						pending.push1   = 1'b1;
						phase_d         = PH_DONE;
					end else begin
						phase_d = PH_MARKER;
					end
				end
				PH_DONE: phase_d = PH_DONE;
				default: phase_d = PH_DONE;
			endcase
		end
		pending.res0 = r0;
		pending.res1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARK;
			tries_q <= '0;
			len_q   <= '0;
			left_q  <= '0;
			sum_q   <= '0;
			rows_q  <= '0;
			bad_q   <= '0;
			good_q  <= '0;
		end else begin
			phase_q <= phase_d;
			tries_q <= tries_d;
			len_q   <= len_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			rows_q  <= rows_d;
			bad_q   <= bad_d;
			good_q  <= good_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE))
		else $error("checker left finished phase");

	a_second_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		pending.push1 |-> (pending.push0 && !pending.res0.last && pending.res1.last))
		else $error("second result without a non-final first result");
`endif

endmodule

### hw/rtl/hrcv_out_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module hrcv_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  hrcv_pkg::push_t   pending,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output hrcv_pkg::res_t    head
);

	hrcv_pkg::res_t mem_q [hrcv_pkg::FIFO_DEPTH];

	logic [hrcv_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [hrcv_pkg::FIFO_CW-1:0] count_q;
	logic [hrcv_pkg::FIFO_CW-1:0] n_push;
	logic                         pop;

	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign n_push    = hrcv_pkg::FIFO_CW'(pending.push0) + hrcv_pkg::FIFO_CW'(pending.push1);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	// space for a worst-case pair of results
	assign room      = (count_q <= hrcv_pkg::FIFO_CW'(hrcv_pkg::FIFO_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (pending.push0) begin
			mem_q[wr_ptr_q] <= pending.res0;
		end
		if (pending.push1) begin
			mem_q[wr_ptr_nx] <= pending.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + hrcv_pkg::FIFO_AW'(n_push);
			rd_ptr_q <= rd_ptr_q + hrcv_pkg::FIFO_AW'(pop);
			count_q  <= count_q + n_push - hrcv_pkg::FIFO_CW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		pending.push0 |-> room)
		else $error("result pushed without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hrcv_pkg::FIFO_CW'(hrcv_pkg::FIFO_DEPTH))
		else $error("result queue count out of range");
`endif

endmodule

### hw/rtl/hex_record_checksum_verifier_unit.sv
// Top level of the HEX record checksum verifier.
`timescale 1ns / 1ps
//
//  channel | signals                                   | direction | accepted when
//  --------+-------------------------------------------+-----------+------------------------
//  in      | in_valid, in_ready, data_byte             | to block  | in_valid && in_ready
//  out     | out_valid, out_ready, event_res .. last   | from block| out_valid && out_ready
//  cfg     | cfg_we, cfg_index, cfg_data               | to block  | cfg_we (no back-pressure)
//
//  One item per cycle while in_ready is high: each byte updates the record
//  walker in the cycle it is accepted and its results land in a four-entry
//  result queue the same edge; the out port shows the head of that queue.
//  in_ready holds while the queue has space for two results (the most one item
//  can cause), so a stalled output never drops a result; with out_ready high
//  the queue drains one result a cycle and input flow is not throttled.
//  Reset clears the walker, counters, registers and queue; no clearing pass.

module hex_record_checksum_verifier_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        event_res,
	output logic [15:0]                       row_index,
	output logic [7:0]                        calc_checksum,
	output logic [7:0]                        stored_checksum,
	output logic [15:0]                       error_count,
	output logic [15:0]                       vertical_sum,
	output logic                              last,
	// configuration
	input  logic                              cfg_we,
	input  logic [hrcv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data
);

	logic [15:0]     global_csum_q;
	logic [15:0]     rows_exp_q;
	logic            room;
	logic            take;
	hrcv_pkg::push_t pending;
	hrcv_pkg::res_t  head;

	// config writes apply at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_csum_q <= '0;
			rows_exp_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				hrcv_pkg::CFG_GLOBAL_CSUM: global_csum_q <= cfg_data;
				hrcv_pkg::CFG_ROWS_EXP:    rows_exp_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = room;
	assign take     = in_valid && room;

	hrcv_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.data_byte       (data_byte),
		.global_checksum (global_csum_q),
		.rows_expected   (rows_exp_q),
		.pending         (pending)
	);

	hrcv_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.pending   (pending),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign event_res       = head.event_res;
	assign row_index       = head.row_index;
	assign calc_checksum   = head.calc_checksum;
	assign stored_checksum = head.stored_checksum;
	assign error_count     = head.error_count;
	assign vertical_sum    = head.vertical_sum;
	assign last            = head.last;

`ifndef NO_ASSERTIONS
	a_ready_tracks_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |-> !pending.push0)
		else $error("result produced for an item not taken");
`endif

endmodule

### dv/testbench.sv
// Self-checking bench for the HEX record checksum verifier: stimulus, predictor and checks.
`timescale 1ns / 1ps

module testbench;

	// Where the byte walker stands, mirrored in the predictor
	typedef enum logic [3:0] {
		WK_MARK, WK_MARKER, WK_COUNT, WK_ADDR_HI, WK_ADDR_LO,
		WK_TYPE, WK_DATA, WK_CSUM, WK_DONE
	} walk_phase_t;

	// Output-side back-pressure styles
	typedef enum int {RX_OPEN, RX_COIN, RX_STALL} rx_mode_t;

	// Predicts the results of every accepted byte and checks results against them
	class record_checksum_board;
		logic [15:0]      global_csum;
		logic [15:0]      row_limit;
		walk_phase_t      walk;
		logic [2:0]       mark_tries;
		logic [7:0]       rec_len;
		logic [7:0]       data_left;
		logic [7:0]       rec_sum;
		logic [15:0]      rows;
		logic [15:0]      bad_recs;
		logic [15:0]      good_sum;
		hrcv_pkg::res_t   expected_q[$];
		int               errors;
		int               records_checked;
		int               bad_checked;
		logic [2:0]       end_event;
		bit               walk_closed;

		function new();
			global_csum = '0;
			row_limit = '0;
			walk = WK_MARK;
			mark_tries = '0;
			rec_len = '0;
			data_left = '0;
			rec_sum = '0;
			rows = '0;
			bad_recs = '0;
			good_sum = '0;
			errors = 0;
			records_checked = 0;
			bad_checked = 0;
			end_event = hrcv_pkg::EV_NO_MARK;
			walk_closed = 0;
		endfunction

		function void set_reg(logic [hrcv_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
			if (idx == hrcv_pkg::CFG_GLOBAL_CSUM) begin
				global_csum = value;
			end else begin
				row_limit = value;
			end
		endfunction

		function void push_result(logic [2:0] ev, logic [15:0] row, logic [7:0] calc,
				logic [7:0] stored, logic [15:0] errs, logic [15:0] vsum, logic lst);
			hrcv_pkg::res_t r;
			r.event_res = ev;
			r.row_index = row;
			r.calc_checksum = calc;
			r.stored_checksum = stored;
			r.error_count = errs;
			r.vertical_sum = vsum;
			r.last = lst;
			expected_q.push_back(r);
		endfunction

		function void close_walk();
			end_event = (good_sum == global_csum) ? hrcv_pkg::EV_FIN_OK :
				hrcv_pkg::EV_FIN_VERR;
			push_result(end_event, rows, 8'h00, 8'h00, bad_recs, good_sum, 1'b1);
			walk = WK_DONE;
			walk_closed = 1;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0]  calc;
			logic [15:0] idx;
			logic        stop;
			case (walk)
				WK_MARK: begin
					mark_tries = mark_tries + 3'd1;
					if (mark_tries >= hrcv_pkg::MARK_LIMIT) begin
						end_event = hrcv_pkg::EV_NO_MARK;
						push_result(hrcv_pkg::EV_NO_MARK, '0, '0, '0, '0, '0, 1'b1);
						walk = WK_DONE;
						walk_closed = 1;
					end else if (b == hrcv_pkg::FILE_MARK) begin
						walk = WK_MARKER;
					end
				end
				WK_MARKER: walk = WK_COUNT;
				WK_COUNT: begin
					rec_len = b;
					data_left = b;
					rec_sum = b;
					walk = WK_ADDR_HI;
				end
				WK_ADDR_HI: begin
					rec_sum = rec_sum + b;
					walk = WK_ADDR_LO;
				end
				WK_ADDR_LO: begin
					rec_sum = rec_sum + b;
					walk = WK_TYPE;
				end
				WK_TYPE: begin
					if (b == hrcv_pkg::EOF_TYPE) begin
						rows = rows + 16'd1;
						close_walk();
					end else begin
						rec_sum = rec_sum + b;
						walk = (rec_len != 8'd0) ? WK_DATA : WK_CSUM;
					end
				end
				WK_DATA: begin
					rec_sum = rec_sum + b;
					data_left = data_left - 8'd1;
					if (data_left == 8'd0) walk = WK_CSUM;
				end
				WK_CSUM: begin
					calc = 8'h00 - rec_sum;
					idx = rows;
					if (calc != b) begin
						if (bad_recs != hrcv_pkg::SAT_MAX) bad_recs = bad_recs + 16'd1;
					end else begin
						good_sum = good_sum + {8'h00, b};
					end
					rows = rows + 16'd1;
					stop = (rows >= row_limit);
					push_result((calc != b) ? hrcv_pkg::EV_REC_BAD : hrcv_pkg::EV_REC_OK,
						idx, calc, b, bad_recs, good_sum, !stop);
					if (stop) begin
						close_walk();
					end else begin
						walk = WK_MARKER;
					end
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int unsigned want_v, int unsigned got_v);
			if (want_v != got_v) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(hrcv_pkg::res_t got);
			hrcv_pkg::res_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, got event %0d row %0d",
					$time, got.event_res, got.row_index);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
			compare_field("row_index", 32'(want.row_index), 32'(got.row_index));
			compare_field("calc_checksum", 32'(want.calc_checksum), 32'(got.calc_checksum));
			compare_field("stored_checksum", 32'(want.stored_checksum),
				32'(got.stored_checksum));
			compare_field("error_count", 32'(want.error_count), 32'(got.error_count));
			compare_field("vertical_sum", 32'(want.vertical_sum), 32'(got.vertical_sum));
			compare_field("last", 32'(want.last), 32'(got.last));
			if (want.event_res == hrcv_pkg::EV_REC_OK ||
					want.event_res == hrcv_pkg::EV_REC_BAD) records_checked++;
			if (want.event_res == hrcv_pkg::EV_REC_BAD) bad_checked++;
		endfunction
	endclass

	// Clock, reset and block pins; every input known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [15:0] row_index;
	logic [7:0]  calc_checksum;
	logic [7:0]  stored_checksum;
	logic [15:0] error_count;
	logic [15:0] vertical_sum;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [hrcv_pkg::CFG_IDX_W-1:0] cfg_index = hrcv_pkg::CFG_GLOBAL_CSUM;
	logic [15:0] cfg_data = 16'h0000;

	record_checksum_board board = new();

	// Image bytes waiting to be sent, and the sender's burst state
	logic [7:0] image_q[$];
	int         burst_left = 0;
	bit         steady = 0;
	int         bytes_sent = 0;

	// Receiver pattern state
	rx_mode_t   rx_mode = RX_OPEN;
	int         rx_window = 0;
	int         rx_stall = 0;

	// Opening bytes: three non-mark bytes so the mark lands on the last allowed
	// try, then a zero-length record with all-ones header, a one-byte record with
	// a wrong checksum, and a two-byte record with a good one.
	logic [7:0] opening [25] = '{
		8'h00, 8'hFF, 8'hA2, hrcv_pkg::FILE_MARK,
		8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h03,
		8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h3A, 8'h02, 8'h12, 8'h34, 8'h02, 8'hFF, 8'h80, 8'h37
	};

	always #5 clk = ~clk;

	hex_record_checksum_verifier_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_res       (event_res),
		.row_index       (row_index),
		.calc_checksum   (calc_checksum),
		.stored_checksum (stored_checksum),
		.error_count     (error_count),
		.vertical_sum    (vertical_sum),
		.last            (last),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Result side: values are sampled as they stood before the edge, then the
	// next ready is chosen. Modes change at random: always ready, coin toss, or
	// stall runs of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				board.check_result({event_res, row_index, calc_checksum, stored_checksum,
					error_count, vertical_sum, last});
			end
			if (rx_window == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_window = $urandom_range(20, 200);
			end
			rx_window--;
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				default: begin
					if (rx_stall == 0) begin
						out_ready <= 1'b1;
						rx_stall = $urandom_range(1, 12);
					end else begin
						out_ready <= 1'b0;
						rx_stall--;
					end
				end
			endcase
		end
	end

	// One byte on the input channel. Bursts of random length with random gaps,
	// unless the phase runs steady. Valid is only lowered for a real gap, so a
	// back-to-back item never sees a low/high pair in one step.
	task send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		board.note_byte(b);
		bytes_sent++;
	endtask

	task send_image();
		while (image_q.size() != 0) send_byte(image_q.pop_front());
	endtask

	// Stop sending and wait until every predicted result is back; the hold-off
	// covers any walker work on bytes that cause no result.
	task drain_results();
		in_valid <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// Both registers, one per cycle; called at a clock edge while idle
	task write_config(input logic [15:0] gsum, input logic [15:0] row_lim);
		cfg_we <= 1'b1;
		cfg_index <= hrcv_pkg::CFG_GLOBAL_CSUM;
		cfg_data <= gsum;
		@(posedge clk);
		board.set_reg(hrcv_pkg::CFG_GLOBAL_CSUM, gsum);
		cfg_index <= hrcv_pkg::CFG_ROWS_EXP;
		cfg_data <= row_lim;
		@(posedge clk);
		board.set_reg(hrcv_pkg::CFG_ROWS_EXP, row_lim);
		cfg_we <= 1'b0;
	endtask

	function logic [7:0] data_type();
		logic [7:0] t;
		do t = 8'($urandom_range(0, 255)); while (t == hrcv_pkg::EOF_TYPE);
		return t;
	endfunction

	// Queue one record; returns the checksum byte it carries (none for end type)
	function logic [7:0] add_record(int len, logic [7:0] rec_type, bit good);
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] csum;
		image_q.push_back(8'($urandom_range(0, 255)));
		image_q.push_back(len[7:0]);
		sum = len[7:0];
		repeat (2) begin
			b = 8'($urandom_range(0, 255));
			image_q.push_back(b);
			sum = sum + b;
		end
		image_q.push_back(rec_type);
		if (rec_type == hrcv_pkg::EOF_TYPE) return 8'h00;
		sum = sum + rec_type;
		repeat (len) begin
			b = 8'($urandom_range(0, 255));
			image_q.push_back(b);
			sum = sum + b;
		end
		csum = 8'h00 - sum;
		if (!good) csum = csum ^ 8'($urandom_range(1, 255));
		image_q.push_back(csum);
		return csum;
	endfunction

	initial begin
		int          n_recs;
		int          len;
		int          pick;
		int          phase_no;
		bit          end_by_type;
		logic [7:0]  csum;
		logic [15:0] gsum;
		logic [15:0] row_lim;
		logic [15:0] final_sum;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both registers at their top values to start with
		write_config(16'hFFFF, 16'hFFFF);
		foreach (opening[i]) send_byte(opening[i]);

		// Random phases of well-formed records, mostly short, mostly good
		// checksums; settings change between phases with everything drained
		phase_no = 0;
		while (bytes_sent < 950) begin
			n_recs = $urandom_range(4, 14);
			drain_results();
			if (phase_no == 1) begin
				gsum = 16'h0000;
			end else if (phase_no == 2) begin
				gsum = 16'hFFFF;
			end else begin
				gsum = 16'($urandom_range(0, 65535));
			end
			// either no limit in reach, or one just past this phase's records
			row_lim = $urandom_range(0, 1) ? 16'hFFFF : 16'(board.rows + n_recs + 1);
			write_config(gsum, row_lim);
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < n_recs; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					len = $urandom_range(0, 8);
				end else if (pick < 97) begin
					len = $urandom_range(9, 40);
				end else begin
					len = $urandom_range(41, 120);
				end
				if (phase_no == 3 && k == 0) len = 255;
				void'(add_record(len, data_type(), $urandom_range(0, 3) != 0));
				send_image();
			end
			phase_no++;
		end

		// Last record: either an end-type record or a normal one stopped by a
		// zero row limit; global sum set to match or not at random
		drain_results();
		steady = 0;
		end_by_type = 1'($urandom_range(0, 1));
		csum = add_record($urandom_range(0, 8),
			end_by_type ? hrcv_pkg::EOF_TYPE : data_type(), 1'b1);
		final_sum = board.good_sum + (end_by_type ? 16'h0000 : {8'h00, csum});
		if ($urandom_range(0, 1)) begin
			gsum = final_sum;
		end else begin
			gsum = final_sum ^ 16'($urandom_range(1, 65535));
		end
		write_config(gsum, 16'h0000);
		send_image();

		// Bytes after the finish are swallowed without a result
		repeat (8) image_q.push_back(8'($urandom_range(0, 255)));
		send_image();
		in_valid <= 1'b0;

		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d bytes, %0d records checked, %0d with a bad checksum",
			bytes_sent, board.records_checked, board.bad_checked);
		$display("walk closed by %s, final event %0d, vertical sum %0d",
			end_by_type ? "end-type record" : "row limit", board.end_event, board.good_sum);
		if (board.errors == 0 && board.expected_q.size() == 0 && board.walk_closed) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// Watchdog, well beyond the slowest legal run
	initial begin
		#3000000;
		$display("testbench failed");
		$finish;
	end

endmodule
